FILE: design/sel_pkg.sv
// ----------------------------------------------------------------------------
// Shared/exclusive lock table package
// Sizes, table entry layout, verdict codes and the decision bundle shared by
// the lock table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sel_pkg;

    localparam int NUM_TRANSACTIONS = 64;
    localparam int NUM_ITEMS        = 256;
    localparam int TID_W            = $clog2(NUM_TRANSACTIONS);
    localparam int ITEM_W           = $clog2(NUM_ITEMS);

    // one bit per transaction
    typedef logic [NUM_TRANSACTIONS-1:0] t_mask;

    // per-item lock state
    typedef struct packed {
        t_mask shared_holders;
        t_mask exclusive_holders;
    } t_entry;

    typedef enum logic [1:0] {
        VERDICT_GRANTED = 2'd0,
        VERDICT_DENIED  = 2'd1,
        VERDICT_IGNORED = 2'd2
    } t_verdict;

    // outcome of one request, from the decision logic to the control
    typedef struct packed {
        t_verdict verdict;
        logic     wr_en;
        logic     deny;
        t_entry   entry;
    } t_decision;

endpackage

`default_nettype wire

FILE: design/sel_mem.sv
// ----------------------------------------------------------------------------
// Lock table storage
// One synchronous memory of per-item holder masks with a registered read,
// plus one valid flop per entry so that a clear empties every entry at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sel_mem
    import sel_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_clr,
    input  wire logic              i_rd_en,
    input  wire logic [ITEM_W-1:0] i_rd_addr,
    output t_entry                 o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [ITEM_W-1:0] i_wr_addr,
    input  wire t_entry            i_wr_data
);

    t_entry                 r_mem [NUM_ITEMS];
    logic [NUM_ITEMS-1:0]   r_vld;
    t_entry                 r_rd_data;
    logic                   r_rd_vld;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // valid bits: clear at reset or on a fresh case, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    // registered read; a clear in the same cycle hides the old contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_vld[i_rd_addr] & ~i_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // an entry never written since the last clear reads as empty
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

FILE: design/sel_decide.sv
// ----------------------------------------------------------------------------
// Lock decision logic
// Compares the requester against the item's holder masks and the denied
// mask, and forms the verdict, the updated entry and the denial flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sel_decide
    import sel_pkg::*;
(
    input  wire logic             i_excl,
    input  wire logic [TID_W-1:0] i_tid,
    input  wire t_entry           i_entry,
    input  wire t_mask            i_denied,
    output t_decision             o_dec
);

    t_mask self;
    t_mask others;

    assign self   = t_mask'(1) << i_tid;
    assign others = ~self;

    // ignore denied transactions, else test for conflicting holders
    always_comb begin
        o_dec         = '0;
        o_dec.verdict = VERDICT_GRANTED;
        o_dec.entry   = i_entry;
        if ((i_denied & self) != '0) begin
            o_dec.verdict = VERDICT_IGNORED;
        end else if (!i_excl) begin
            if ((i_entry.exclusive_holders & others) != '0) begin
                o_dec.verdict = VERDICT_DENIED;
                o_dec.deny    = 1'b1;
            end else begin
                o_dec.entry.shared_holders = i_entry.shared_holders | self;
                o_dec.wr_en                = 1'b1;
            end
        end else begin
            if (((i_entry.shared_holders | i_entry.exclusive_holders) & others) != '0) begin
                o_dec.verdict = VERDICT_DENIED;
                o_dec.deny    = 1'b1;
            end else begin
                o_dec.entry.exclusive_holders = i_entry.exclusive_holders | self;
                o_dec.wr_en                   = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/shared_exclusive_lock_table.sv
// Flow: the edge that accepts a request registers the table read data and
// raises busy; in the busy cycle the entry is decided and written back and
// the verdict is registered with o_strobe. Busy is high for the cycle in
// which the read data is decided and written back, so no read meets a
// pending write. The receiver cannot stall, so nothing else holds it off.
// Reset: synchronous; the denied mask is cleared and all holder masks read
// as empty at once through per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
// Shared/exclusive lock table
// Grants or denies shared and exclusive lock requests per data item and
// tracks transactions that have been denied.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_exclusive_lock_table
    import sel_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_func,
    input  wire logic [TID_W-1:0]  i_trans_id,
    input  wire logic [ITEM_W-1:0] i_item_id,
    input  wire logic              i_new_case,
    output logic                   o_strobe,
    output logic [1:0]             o_verdict
);

    logic              accept;
    logic              r_busy;
    logic              r_excl;
    logic [TID_W-1:0]  r_tid;
    logic [ITEM_W-1:0] r_item;
    t_mask             r_denied;
    t_mask             n_denied;
    logic              r_strobe;
    t_verdict          r_verdict;
    t_entry            rd_entry;
    t_decision         dec;

    assign accept = start & ~r_busy;
    assign busy   = r_busy;

    sel_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (accept & i_new_case),
        .i_rd_en   (accept),
        .i_rd_addr (i_item_id),
        .o_rd_data (rd_entry),
        .i_wr_en   (r_busy & dec.wr_en),
        .i_wr_addr (r_item),
        .i_wr_data (dec.entry)
    );

    sel_decide u_decide (
        .i_excl   (r_excl),
        .i_tid    (r_tid),
        .i_entry  (rd_entry),
        .i_denied (r_denied),
        .o_dec    (dec)
    );

    // hold the request while the table read completes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_excl <= i_func;
            r_tid  <= i_trans_id;
            r_item <= i_item_id;
        end
    end

    // drop the denied mask on a fresh case, add to it on a denial
    always_comb begin
        n_denied = r_denied;
        if (accept && i_new_case) begin
            n_denied = '0;
        end else if (r_busy && dec.deny) begin
            n_denied = r_denied | (t_mask'(1) << r_tid);
        end
    end

    // advance control and register the verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_denied <= '0;
        end else begin
            r_busy   <= accept;
            r_strobe <= r_busy;
            r_denied <= n_denied;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_verdict <= dec.verdict;
        end
    end

    assign o_strobe  = r_strobe;
    assign o_verdict = r_verdict;

endmodule

`default_nettype wire

FILE: design/sel_checker.sv
// ----------------------------------------------------------------------------
// Lock table port checker
// Checks request-to-verdict timing and verdict codes at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module sel_checker
    import sel_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic [1:0] o_verdict
);

    logic accept;

    assign accept = start & ~busy & i_rst_n;

    // a request blocks the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after request");

    // every request gets its verdict strobe after its busy cycle
    a_verdict_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_strobe)
        else $error("verdict missing two cycles after request");

    // no verdict strobe without a matching earlier request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 2))
        else $error("verdict without request");

    // the block is free again when the verdict shows
    a_free_at_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("busy while verdict shown");

    // verdict is a defined code
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_verdict == VERDICT_GRANTED || o_verdict == VERDICT_DENIED
                      || o_verdict == VERDICT_IGNORED))
        else $error("undefined verdict code");

endmodule

bind shared_exclusive_lock_table sel_checker u_sel_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_strobe  (o_strobe),
    .o_verdict (o_verdict)
);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lock table testbench
// Sends shared and exclusive lock requests to the lock table: first a short
// table of hand-picked requests, then random sessions that mostly open with a
// cleared table and work a small pool of transactions and items, so that
// grants, denials, upgrades and ignored requests all occur. Every verdict is
// predicted in the bench and compared, in order, with the block's output.
// ----------------------------------------------------------------------------

module testbench;
    import sel_pkg::*;

    localparam int       N_RANDOM  = 2000;
    localparam int       TIMEOUT   = 5_000_000;   // ns
    localparam logic     MODE_SH   = 1'b0;
    localparam logic     MODE_EX   = 1'b1;

    // one row of the directed table; known rows carry their verdict
    typedef struct packed {
        logic              func;
        logic [TID_W-1:0]  tid;
        logic [ITEM_W-1:0] item;
        logic              new_case;
        logic              known;
        t_verdict          verdict;
    } t_lock_row;

    localparam int N_DIRECTED = 22;
    localparam t_lock_row DIRECTED [N_DIRECTED] = '{
        // after reset everything is free
        '{MODE_SH,  0,   0, 1'b0, 1'b1, VERDICT_GRANTED},
        '{MODE_EX, 63, 255, 1'b0, 1'b1, VERDICT_GRANTED},
        // shared against a foreign exclusive holder
        '{MODE_SH,  0, 255, 1'b0, 1'b1, VERDICT_DENIED},
        // a denied transaction is ignored from now on
        '{MODE_SH,  0,   1, 1'b0, 1'b1, VERDICT_IGNORED},
        '{MODE_EX,  0,   0, 1'b0, 1'b1, VERDICT_IGNORED},
        // re-request, sole-holder upgrade, exclusive holder asking shared
        '{MODE_SH,  5,  10, 1'b0, 1'b1, VERDICT_GRANTED},
        '{MODE_SH,  5,  10, 1'b0, 1'b0, VERDICT_GRANTED},
        '{MODE_EX,  5,  10, 1'b0, 1'b0, VERDICT_GRANTED},
        '{MODE_SH,  5,  10, 1'b0, 1'b0, VERDICT_GRANTED},
        '{MODE_SH,  6,  10, 1'b0, 1'b1, VERDICT_DENIED},
        // upgrade blocked by a second shared holder
        '{MODE_SH,  7,  20, 1'b0, 1'b1, VERDICT_GRANTED},
        '{MODE_SH,  8,  20, 1'b0, 1'b0, VERDICT_GRANTED},
        '{MODE_EX,  8,  20, 1'b0, 1'b1, VERDICT_DENIED},
        '{MODE_EX,  8,  21, 1'b0, 1'b1, VERDICT_IGNORED},
        // a new case wipes locks and denials
        '{MODE_EX,  0, 255, 1'b1, 1'b1, VERDICT_GRANTED},
        '{MODE_SH, 63, 255, 1'b0, 1'b1, VERDICT_DENIED},
        '{MODE_EX, 63,   0, 1'b0, 1'b1, VERDICT_IGNORED},
        '{MODE_SH, 63,   0, 1'b1, 1'b1, VERDICT_GRANTED},
        '{MODE_EX, 62, 128, 1'b0, 1'b1, VERDICT_GRANTED},
        '{MODE_EX, 62, 128, 1'b0, 1'b0, VERDICT_GRANTED},
        '{MODE_SH, 42, 128, 1'b0, 1'b1, VERDICT_DENIED},
        '{MODE_SH, 21, 127, 1'b0, 1'b1, VERDICT_GRANTED}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_func;
    logic [TID_W-1:0]  i_trans_id;
    logic [ITEM_W-1:0] i_item_id;
    logic              i_new_case;
    logic              o_strobe;
    logic [1:0]        o_verdict;

    // bench copy of the lock state
    t_mask    shared_tab [NUM_ITEMS];
    t_mask    excl_tab   [NUM_ITEMS];
    t_mask    denied_set;

    t_verdict verdicts_due [$];
    logic     req_known;
    t_verdict req_verdict;
    int       n_mismatch;
    int       n_requests;
    int       n_cases;
    int       n_seen [3];

    shared_exclusive_lock_table u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_func     (i_func),
        .i_trans_id (i_trans_id),
        .i_item_id  (i_item_id),
        .i_new_case (i_new_case),
        .o_strobe   (o_strobe),
        .o_verdict  (o_verdict)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        #TIMEOUT;
        $display("Timeout at %0t with %0d verdicts outstanding", $time, verdicts_due.size());
        $display("Mismatches found");
        $finish;
    end

    // clear the whole lock state
    function automatic void wipe_locks();
        for (int i = 0; i < NUM_ITEMS; i++) begin
            shared_tab[i] = '0;
            excl_tab[i]   = '0;
        end
        denied_set = '0;
    endfunction

    // decide one request and update the lock state
    function automatic t_verdict decide_lock(input logic func, input logic [TID_W-1:0] tid,
                                             input logic [ITEM_W-1:0] item, input logic fresh);
        t_mask    self;
        t_verdict v;
        self = t_mask'(1) << tid;
        if (fresh)
            wipe_locks();
        if ((denied_set & self) != '0) begin
            v = VERDICT_IGNORED;
        end else if (func == MODE_SH) begin
            if ((excl_tab[item] & ~self) != '0) begin
                denied_set |= self;
                v = VERDICT_DENIED;
            end else begin
                shared_tab[item] |= self;
                v = VERDICT_GRANTED;
            end
        end else begin
            if (((shared_tab[item] | excl_tab[item]) & ~self) != '0) begin
                denied_set |= self;
                v = VERDICT_DENIED;
            end else begin
                excl_tab[item] |= self;
                v = VERDICT_GRANTED;
            end
        end
        return v;
    endfunction

    // check verdicts first, then log the request taken at this edge
    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (i_rst_n && o_strobe) begin
            got = t_verdict'(o_verdict);
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, actual %0d", $time, o_verdict);
                n_mismatch++;
            end else begin
                want = verdicts_due.pop_front();
                if (got !== want) begin
                    $display("%0t: verdict mismatch, expected %0d, actual %0d",
                             $time, want, o_verdict);
                    n_mismatch++;
                end
                if (want <= VERDICT_IGNORED)
                    n_seen[want]++;
            end
        end
        if (i_rst_n && start && !busy) begin
            want = decide_lock(i_func, i_trans_id, i_item_id, i_new_case);
            verdicts_due.push_back(req_known ? req_verdict : want);
            n_requests++;
            if (i_new_case)
                n_cases++;
        end
    end

    // present one request at a falling edge and hold it until taken
    task automatic send_request(input logic func, input logic [TID_W-1:0] tid,
                                input logic [ITEM_W-1:0] item, input logic fresh,
                                input int gap, input logic known, input t_verdict v);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      <= 1'b1;
        i_func     <= func;
        i_trans_id <= tid;
        i_item_id  <= item;
        i_new_case <= fresh;
        req_known   = known;
        req_verdict = v;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int                burst_left;
        int                case_left;
        int                gap;
        int                wait_cycles;
        logic [TID_W-1:0]  tid_base;
        logic [ITEM_W-1:0] item_base;
        logic [TID_W-1:0]  tid;
        logic [ITEM_W-1:0] item;
        logic              func;
        logic              fresh;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_func      = 1'b0;
        i_trans_id  = '0;
        i_item_id   = '0;
        i_new_case  = 1'b0;
        req_known   = 1'b0;
        req_verdict = VERDICT_GRANTED;
        n_mismatch  = 0;
        n_requests  = 0;
        n_cases     = 0;
        n_seen      = '{0, 0, 0};
        burst_left  = 0;
        case_left   = 0;
        tid_base    = '0;
        item_base   = '0;
        wipe_locks();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // walk the directed table
        foreach (DIRECTED[r])
            send_request(DIRECTED[r].func, DIRECTED[r].tid, DIRECTED[r].item,
                         DIRECTED[r].new_case, $urandom_range(0, 7),
                         DIRECTED[r].known, DIRECTED[r].verdict);

        // random sessions over small pools of transactions and items
        for (int n = 0; n < N_RANDOM; n++) begin
            fresh = 1'b0;
            if (case_left == 0) begin
                case_left = $urandom_range(4, 48);
                tid_base  = TID_W'($urandom_range(0, NUM_TRANSACTIONS - 1));
                item_base = ITEM_W'($urandom_range(0, NUM_ITEMS - 1));
                fresh     = ($urandom_range(0, 9) != 0);
            end
            case_left--;
            if ($urandom_range(0, 7) == 0) begin
                tid   = TID_W'($urandom_range(0, NUM_TRANSACTIONS - 1));
                item  = ITEM_W'($urandom_range(0, NUM_ITEMS - 1));
                func  = 1'($urandom_range(0, 1));
                fresh = fresh | ($urandom_range(0, 15) == 0);
            end else begin
                tid  = tid_base + TID_W'($urandom_range(0, 5));
                item = item_base + ITEM_W'($urandom_range(0, 3));
                func = ($urandom_range(0, 2) == 0) ? MODE_EX : MODE_SH;
            end
            // alternate back-to-back bursts with random gaps
            if (burst_left == 0 && $urandom_range(0, 15) == 0)
                burst_left = $urandom_range(10, 40);
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else begin
                gap = $urandom_range(0, 7);
            end
            send_request(func, tid, item, fresh, gap, 1'b0, VERDICT_GRANTED);
        end
        start <= 1'b0;

        // drain outstanding verdicts, then idle before the final check
        wait_cycles = 0;
        while (verdicts_due.size() != 0 && wait_cycles < 1000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (verdicts_due.size() != 0) begin
            $display("%0t: %0d verdicts never arrived, expected %0d first, actual none",
                     $time, verdicts_due.size(), verdicts_due[0]);
            n_mismatch++;
        end

        $display("Ran %0d requests over %0d fresh cases", n_requests, n_cases);
        $display("Verdicts checked: %0d granted, %0d denied, %0d ignored",
                 n_seen[0], n_seen[1], n_seen[2]);
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
